FILE: rtl/occupancy_duty_cycle_meter_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the occupancy duty-cycle meter
// Concurrent checks on clk_i, disabled while rst_ni is low. Empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef OCCUPANCY_DUTY_CYCLE_METER_MACROS_SVH
`define OCCUPANCY_DUTY_CYCLE_METER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define ODCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("odcm same-cycle check failed");
// next-cycle implication
`define ODCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("odcm next-cycle check failed");
`else
`define ODCM_ASSERT_IMP(lbl, ante, cons)
`define ODCM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/odcm_pkg.sv
// ---------------------------------------------------------------------------
// odcm_pkg
// Shared types and constants of the occupancy duty-cycle meter.
// ---------------------------------------------------------------------------
package odcm_pkg;

  localparam int unsigned TS_W  = 16;              // timestamp / accumulator width
  localparam int unsigned CNT_W = $clog2(TS_W);    // bit counter of the serial units
  localparam int unsigned TOT_W = TS_W + 1;        // high + low

  localparam logic [TS_W-1:0] ACC_MAX = '1;
  localparam logic [TS_W-1:0] Q15_ONE = 16'd32768;

  typedef enum logic [1:0] {
    KIND_EDGE    = 2'd0,
    KIND_REPORT  = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  typedef struct packed {
    logic done;
    logic carry;
  } acc_stat_t;

endpackage

FILE: rtl/odcm_if.sv
// ---------------------------------------------------------------------------
// odcm request / result channels
// Valid/ready channels carrying the meter's input requests and its reports.
// ---------------------------------------------------------------------------
interface odcm_in_if;
  import odcm_pkg::*;

  logic            valid;
  logic            ready;
  logic [1:0]      kind;
  logic [TS_W-1:0] timestamp;
  logic            pin_level;

  modport source (output valid, output kind, output timestamp, output pin_level,
                  input ready);
  modport sink   (input valid, input kind, input timestamp, input pin_level,
                  output ready);
endinterface

interface odcm_out_if;
  import odcm_pkg::*;

  logic            valid;
  logic            ready;
  logic [TS_W-1:0] occupancy;
  logic [TS_W-1:0] high_total;
  logic [TS_W-1:0] low_total;
  logic            saturated;

  modport source (output valid, output occupancy, output high_total, output low_total,
                  output saturated, input ready);
  modport sink   (input valid, input occupancy, input high_total, input low_total,
                  input saturated, output ready);
endinterface

FILE: rtl/occupancy_duty_cycle_meter.sv
// ---------------------------------------------------------------------------
// occupancy_duty_cycle_meter
// Duty-cycle meter for a motion-sensor line, bit-serial datapath.
// ---------------------------------------------------------------------------
// Usage:
//   in_i  : requests {kind, timestamp, pin_level}. kind edge adds the modulo
//           2^16 time since the last latched stamp to low time (pin rose) or
//           high time (pin fell), saturating at 65535 with a sticky flag.
//           kind report returns one result and clears; kind restart clears
//           and latches the stamp. Kind 3 is dropped.
//   out_o : one result per report: occupancy (Q1.15), both totals, saturated.
// Timing: requests are taken only when the meter is idle. An edge runs
//   through the serial adder and frees the input once the new total is
//   written back; a restart is done within the idle state. A report runs
//   the serial adder for the total and then the restoring divider, one
//   quotient bit per cycle, before its result is pushed out; when both
//   totals are zero the divider is skipped.
// Reset: all totals, the latched stamp and the flag clear to zero.
// Stall: the result waits in an output register; edges and restarts still go
//   ahead, a later report waits until the register is taken.
// ---------------------------------------------------------------------------
module occupancy_duty_cycle_meter (
  input  logic clk_i,
  input  logic rst_ni,
  odcm_in_if.sink    in_i,
  odcm_out_if.source out_o
);
  import odcm_pkg::*;
  `include "occupancy_duty_cycle_meter_macros.svh"

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE,
    ST_SUM,
    ST_DIV,
    ST_PUSH
  } state_e;

  state_e          state_q;
  logic [TS_W-1:0] high_q, low_q, last_q, ts_q, occ_q;
  logic            ovf_q, lvl_q;
  logic            out_valid_q;
  logic [TS_W-1:0] out_occ_q, out_high_q, out_low_q;
  logic            out_sat_q;

  logic            in_ready, in_fire, out_free;
  logic            acc_start, div_start, div_done;
  logic [TS_W-1:0] acc_a, acc_b, acc_c, acc_sum, div_quot;
  logic [TOT_W-1:0] total;
  acc_stat_t       acc_stat;

  assign in_ready = (state_q == ST_IDLE);
  assign in_fire  = in_i.valid && in_ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign total    = {acc_stat.carry, acc_sum};

  always_comb begin
    acc_start = 1'b0;
    acc_a     = high_q;
    acc_b     = low_q;
    acc_c     = '0;
    case (in_i.kind)
      KIND_EDGE: begin
        acc_start = in_fire;
        acc_a     = in_i.pin_level ? low_q : high_q;
        acc_b     = in_i.timestamp;
        acc_c     = last_q;
      end
      KIND_REPORT: begin
        acc_start = in_fire;
      end
      default: ;
    endcase
  end

  assign div_start = (state_q == ST_SUM) && acc_stat.done && (total != '0);

  odcm_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (acc_start),
    .a_i     (acc_a),
    .b_i     (acc_b),
    .c_i     (acc_c),
    .sum_o   (acc_sum),
    .stat_o  (acc_stat)
  );

  odcm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (high_q),
    .den_i   (total),
    .quot_o  (div_quot),
    .done_o  (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      high_q      <= '0;
      low_q       <= '0;
      last_q      <= '0;
      ovf_q       <= 1'b0;
      ts_q        <= '0;
      lvl_q       <= 1'b0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
      out_occ_q   <= '0;
      out_high_q  <= '0;
      out_low_q   <= '0;
      out_sat_q   <= 1'b0;
    end else begin
      // ST_PUSH refills the register itself when it is taken
      if (out_valid_q && out_o.ready && (state_q != ST_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            ts_q  <= in_i.timestamp;
            lvl_q <= in_i.pin_level;
            case (in_i.kind)
              KIND_EDGE:   state_q <= ST_EDGE;
              KIND_REPORT: state_q <= ST_SUM;
              KIND_RESTART: begin
                high_q <= '0;
                low_q  <= '0;
                ovf_q  <= 1'b0;
                last_q <= in_i.timestamp;
              end
              default: ;
            endcase
          end
        end
        ST_EDGE: begin
          if (acc_stat.done) begin
            if (lvl_q) begin
              low_q <= acc_stat.carry ? ACC_MAX : acc_sum;
            end else begin
              high_q <= acc_stat.carry ? ACC_MAX : acc_sum;
            end
            if (acc_stat.carry) begin
              ovf_q <= 1'b1;
            end
            last_q  <= ts_q;
            state_q <= ST_IDLE;
          end
        end
        ST_SUM: begin
          if (acc_stat.done) begin
            if (total == '0) begin
              occ_q   <= '0;
              state_q <= ST_PUSH;
            end else begin
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            occ_q   <= div_quot;
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_occ_q   <= occ_q;
            out_high_q  <= high_q;
            out_low_q   <= low_q;
            out_sat_q   <= ovf_q;
            high_q      <= '0;
            low_q       <= '0;
            ovf_q       <= 1'b0;
            last_q      <= ts_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.occupancy  = out_occ_q;
  assign out_o.high_total = out_high_q;
  assign out_o.low_total  = out_low_q;
  assign out_o.saturated  = out_sat_q;

  `ODCM_ASSERT_IMP(a_acc_done_owned, acc_stat.done, (state_q == ST_EDGE) || (state_q == ST_SUM))
  `ODCM_ASSERT_IMP(a_div_done_owned, div_done, state_q == ST_DIV)
  `ODCM_ASSERT_NXT(a_sat_sets_flag, (state_q == ST_EDGE) && acc_stat.done && acc_stat.carry, ovf_q)
  `ODCM_ASSERT_IMP(a_occ_range, out_valid_q, out_occ_q <= Q15_ONE)

endmodule

FILE: rtl/odcm_acc.sv
// ---------------------------------------------------------------------------
// odcm_acc
// Bit-serial a + (b - c), LSB first, one bit per cycle; carry out kept.
// ---------------------------------------------------------------------------
module odcm_acc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [odcm_pkg::TS_W-1:0]   a_i,
  input  logic [odcm_pkg::TS_W-1:0]   b_i,
  input  logic [odcm_pkg::TS_W-1:0]   c_i,
  output logic [odcm_pkg::TS_W-1:0]   sum_o,
  output odcm_pkg::acc_stat_t         stat_o
);
  import odcm_pkg::*;

  logic [TS_W-1:0]  a_q, b_q, c_q;
  logic             carry_q, borrow_q;
  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;

  logic diff_bit, borrow_d, sum_bit, carry_d;

  // modulo subtract feeding straight into the add
  always_comb begin
    diff_bit = b_q[0] ^ c_q[0] ^ borrow_q;
    borrow_d = (~b_q[0] & c_q[0]) | (~(b_q[0] ^ c_q[0]) & borrow_q);
    sum_bit  = a_q[0] ^ diff_bit ^ carry_q;
    carry_d  = (a_q[0] & diff_bit) | (a_q[0] & carry_q) | (diff_bit & carry_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(TS_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // a_q doubles as the sum shift register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q      <= a_i;
      b_q      <= b_i;
      c_q      <= c_i;
      carry_q  <= 1'b0;
      borrow_q <= 1'b0;
    end else if (busy_q) begin
      a_q      <= {sum_bit, a_q[TS_W-1:1]};
      b_q      <= {1'b0, b_q[TS_W-1:1]};
      c_q      <= {1'b0, c_q[TS_W-1:1]};
      carry_q  <= carry_d;
      borrow_q <= borrow_d;
    end
  end

  assign sum_o        = a_q;
  assign stat_o.done  = done_q;
  assign stat_o.carry = carry_q;

endmodule

FILE: rtl/odcm_div.sv
// ---------------------------------------------------------------------------
// odcm_div
// Restoring divider for num * 2^15 / den, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module odcm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [odcm_pkg::TS_W-1:0]   num_i,
  input  logic [odcm_pkg::TOT_W-1:0]  den_i,
  output logic [odcm_pkg::TS_W-1:0]   quot_o,
  output logic                        done_o
);
  import odcm_pkg::*;

  logic [TOT_W-1:0] rem_q, den_q, rem_d;
  logic [TS_W-1:0]  quot_q;
  logic             nb_q;
  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;

  logic [TOT_W:0]   trial, diff;
  logic             ge;

  always_comb begin
    trial = {rem_q, nb_q};
    diff  = trial - {1'b0, den_q};
    ge    = ~diff[TOT_W];
    rem_d = ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(TS_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // dividend is num << 15; its top bits start as the remainder (num >> 1 < den),
  // then num[0] and zeros are brought in one per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {2'b00, num_i[TS_W-1:1]};
      nb_q   <= num_i[0];
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      nb_q   <= 1'b0;
      quot_q <= {quot_q[TS_W-2:0], ge};
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule
